// File: rtl/alat_pkg.sv
// Shared constants, types and helpers of the alarm annunciator table.
package alat_pkg;

  localparam int CHANNELS = 64;
  localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W    = $clog2(CHANNELS + 1);
  localparam int CHAN_W   = 6;
  localparam int CMP_W    = (CNT_W > CHAN_W) ? CNT_W : CHAN_W;
  localparam int TYPE_W   = 8;
  localparam int NUM_W    = 16;
  localparam int IDENT_W  = TYPE_W + NUM_W;
  localparam int FLAG_W   = 3;
  localparam int CHG_W    = 16;

  localparam logic signed [7:0] FAULT_A = -8'sd1;
  localparam logic signed [7:0] FAULT_B = -8'sd2;
  localparam logic signed [7:0] FAULT_C = -8'sd3;
  localparam logic signed [7:0] FAULT_D = -8'sd12;
  localparam logic signed [7:0] FAULT_E = -8'sd13;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_SCAN     = 2'd1,
    OP_COMMAND  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CMD_SUPPRESS   = 2'd0,
    CMD_UNSUPPRESS = 2'd1,
    CMD_ACK        = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ALM_NORMAL   = 2'd0,
    ALM_ALARM    = 2'd1,
    ALM_ACK      = 2'd2,
    ALM_RETURNED = 2'd3
  } astate_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_REFUSED = 3'd1,
    STAT_BAD     = 3'd2,
    STAT_NOMATCH = 3'd3,
    STAT_FULL    = 3'd4
  } stat_t;

  // One port's worth of memory control: a write and a read per cycle.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_ctl_t;

  function automatic logic is_fault(input logic signed [7:0] v);
    return v inside {FAULT_A, FAULT_B, FAULT_C, FAULT_D, FAULT_E};
  endfunction

endpackage

// File: rtl/alarm_annunciator_table_top.sv
// Top level of the alarm annunciator table.
//
// Request channel (in_valid / in_stall): one request is taken when in_valid
// is high and in_stall low. op selects register, scan or operator command.
// Result channel (out_valid / out_stall): exactly one result per request,
// held stable in the output register while out_stall is high.
// A register, an unknown op, a scan of an unregistered channel and a command
// on an empty table go straight to S_FINISH; a scan of a registered channel
// passes S_EVAL first, and any other command passes S_SEARCH. In S_FINISH the
// result moves into the output register, and the block can then take the next
// request; a command lookup walks the identity memory one entry a cycle until
// it finds a match or reaches the fill count.
// The state and identity of the channels live in two synchronous RAMs with
// registered read data; the sequencer reads, modifies and writes back.
// Only one request is in flight, so no access to an entry can overlap.
// A finished result may wait in the output register while a new request is
// accepted; the sequencer holds the next result until the register frees.
// Reset (rst, synchronous) empties the table and clears the round flags and
// the change counter. The RAMs are not cleared: entries at or beyond the
// fill count are never read, and registering a channel writes all of it.
module alarm_annunciator_table_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  op,
  input  logic [alat_pkg::CHAN_W-1:0] channel,
  input  logic                        first_of_round,
  input  logic                        last_of_round,
  input  logic signed [7:0]           device_state,
  input  logic [1:0]                  command,
  input  logic [alat_pkg::TYPE_W-1:0] dev_type,
  input  logic [alat_pkg::NUM_W-1:0]  dev_serial,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  status,
  output logic [1:0]                  alarm_state,
  output logic                        suppressed,
  output logic                        any_error,
  output logic                        new_error,
  output logic [alat_pkg::CHG_W-1:0]  change_id
);
  import alat_pkg::*;

  mem_ctl_t           id_ctl;
  mem_ctl_t           fl_ctl;
  logic [IDENT_W-1:0] id_wdata;
  logic [IDENT_W-1:0] id_rdata;
  logic [FLAG_W-1:0]  fl_wdata;
  logic [FLAG_W-1:0]  fl_rdata;

  // Identity memory: {type, number} per channel.
  alat_ram #(.WIDTH(IDENT_W)) u_ident_ram (
    .clk   (clk),
    .ctl   (id_ctl),
    .wdata (id_wdata),
    .rdata (id_rdata)
  );

  // Flag memory: {alarm state, suppress} per channel.
  alat_ram #(.WIDTH(FLAG_W)) u_flag_ram (
    .clk   (clk),
    .ctl   (fl_ctl),
    .wdata (fl_wdata),
    .rdata (fl_rdata)
  );

  alat_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .channel        (channel),
    .first_of_round (first_of_round),
    .last_of_round  (last_of_round),
    .device_state   (device_state),
    .command        (command),
    .dev_type       (dev_type),
    .dev_serial     (dev_serial),
    .id_ctl         (id_ctl),
    .id_wdata       (id_wdata),
    .id_rdata       (id_rdata),
    .fl_ctl         (fl_ctl),
    .fl_wdata       (fl_wdata),
    .fl_rdata       (fl_rdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .alarm_state    (alarm_state),
    .suppressed     (suppressed),
    .any_error      (any_error),
    .new_error      (new_error),
    .change_id      (change_id)
  );

endmodule

// File: rtl/alat_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module alat_ram #(
  parameter int WIDTH = 8
) (
  input  logic                 clk,
  input  alat_pkg::mem_ctl_t   ctl,
  input  logic [WIDTH-1:0]     wdata,
  output logic [WIDTH-1:0]     rdata
);
  import alat_pkg::*;

  logic [WIDTH-1:0] mem [CHANNELS];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata <= mem[ctl.raddr];
    end
  end

endmodule

// File: rtl/alat_ctrl.sv
// Sequencer: takes one request, runs the memory accesses and holds the result.
module alat_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      op,
  input  logic [alat_pkg::CHAN_W-1:0]     channel,
  input  logic                            first_of_round,
  input  logic                            last_of_round,
  input  logic signed [7:0]               device_state,
  input  logic [1:0]                      command,
  input  logic [alat_pkg::TYPE_W-1:0]     dev_type,
  input  logic [alat_pkg::NUM_W-1:0]      dev_serial,
  output alat_pkg::mem_ctl_t              id_ctl,
  output logic [alat_pkg::IDENT_W-1:0]    id_wdata,
  input  logic [alat_pkg::IDENT_W-1:0]    id_rdata,
  output alat_pkg::mem_ctl_t              fl_ctl,
  output logic [alat_pkg::FLAG_W-1:0]     fl_wdata,
  input  logic [alat_pkg::FLAG_W-1:0]     fl_rdata,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      status,
  output logic [1:0]                      alarm_state,
  output logic                            suppressed,
  output logic                            any_error,
  output logic                            new_error,
  output logic [alat_pkg::CHG_W-1:0]      change_id
);
  import alat_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_EVAL   = 4'b0100,
    S_FINISH = 4'b1000
  } fsm_t;

  fsm_t              state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              round_fault, round_fault_next;
  logic              round_changed, round_changed_next;
  logic [CHG_W-1:0]  change_count, change_count_next;

  logic [ADDR_W-1:0] idx, idx_next;
  logic              it_last, it_last_next;
  logic              it_fault, it_fault_next;
  logic [1:0]        it_cmd, it_cmd_next;
  logic [TYPE_W-1:0] it_type, it_type_next;
  logic [NUM_W-1:0]  it_num, it_num_next;
  stat_t             res_status, res_status_next;
  astate_t           res_state, res_state_next;
  logic              res_supp, res_supp_next;

  stat_t             out_status;
  astate_t           out_state;
  logic              out_load;
  logic              accept;

  always_comb begin
    astate_t s_cur;
    astate_t s_new;
    logic    sup_new;
    logic    chg;
    logic    rf;
    logic    rc;
    stat_t   st;

    state_next         = state;
    count_next         = count;
    round_fault_next   = round_fault;
    round_changed_next = round_changed;
    change_count_next  = change_count;
    idx_next           = idx;
    it_last_next       = it_last;
    it_fault_next      = it_fault;
    it_cmd_next        = it_cmd;
    it_type_next       = it_type;
    it_num_next        = it_num;
    res_status_next    = res_status;
    res_state_next     = res_state;
    res_supp_next      = res_supp;
    id_ctl             = '0;
    fl_ctl             = '0;
    id_wdata           = {dev_type, dev_serial};
    fl_wdata           = '0;
    out_load           = 1'b0;
    s_cur              = astate_t'(fl_rdata[2:1]);
    s_new              = s_cur;
    sup_new            = fl_rdata[0];
    chg                = 1'b0;
    rf                 = round_fault;
    rc                 = round_changed;
    st                 = STAT_OK;

    in_stall = (state != S_IDLE);
    accept   = in_valid && !in_stall;

    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_FINISH;
          case (op)
            OP_REGISTER: begin
              res_state_next = ALM_NORMAL;
              res_supp_next  = 1'b0;
              if (count == CNT_W'(CHANNELS)) begin
                res_status_next = STAT_FULL;
              end else begin
                // Append at the fill count; a new channel starts normal.
                id_ctl.we       = 1'b1;
                id_ctl.waddr    = count[ADDR_W-1:0];
                fl_ctl.we       = 1'b1;
                fl_ctl.waddr    = count[ADDR_W-1:0];
                fl_wdata        = {ALM_NORMAL, 1'b0};
                count_next      = count + CNT_W'(1);
                res_status_next = STAT_OK;
              end
            end
            OP_SCAN: begin
              rf                 = first_of_round ? 1'b0 : round_fault;
              rc                 = first_of_round ? 1'b0 : round_changed;
              round_fault_next   = rf;
              round_changed_next = rc;
              if (CMP_W'(channel) < CMP_W'(count)) begin
                fl_ctl.re     = 1'b1;
                fl_ctl.raddr  = ADDR_W'(channel);
                idx_next      = ADDR_W'(channel);
                it_last_next  = last_of_round;
                it_fault_next = is_fault(device_state);
                state_next    = S_EVAL;
              end else begin
                res_status_next = STAT_NOMATCH;
                res_state_next  = ALM_NORMAL;
                res_supp_next   = 1'b0;
                if (last_of_round && rc) begin
                  change_count_next = change_count + CHG_W'(1);
                end
              end
            end
            OP_COMMAND: begin
              it_cmd_next  = command;
              it_type_next = dev_type;
              it_num_next  = dev_serial;
              if (count == '0) begin
                res_status_next = STAT_NOMATCH;
                res_state_next  = ALM_NORMAL;
                res_supp_next   = 1'b0;
              end else begin
                // Start the lookup at entry zero in both memories.
                id_ctl.re    = 1'b1;
                id_ctl.raddr = '0;
                fl_ctl.re    = 1'b1;
                fl_ctl.raddr = '0;
                idx_next     = '0;
                state_next   = S_SEARCH;
              end
            end
            default: begin
              res_status_next = STAT_BAD;
              res_state_next  = ALM_NORMAL;
              res_supp_next   = 1'b0;
            end
          endcase
        end
      end

      S_EVAL: begin
        if (it_fault) begin
          if (s_cur == ALM_NORMAL || s_cur == ALM_RETURNED) begin
            s_new = ALM_ALARM;
            chg   = 1'b1;
          end
        end else if (s_cur == ALM_ACK) begin
          s_new = ALM_NORMAL;
          chg   = 1'b1;
        end else if (s_cur == ALM_ALARM) begin
          s_new = ALM_RETURNED;
          chg   = 1'b1;
        end
        fl_ctl.we          = 1'b1;
        fl_ctl.waddr       = idx;
        fl_wdata           = {s_new, fl_rdata[0]};
        rc                 = round_changed | chg;
        round_fault_next   = round_fault | it_fault;
        round_changed_next = rc;
        if (it_last && rc) begin
          change_count_next = change_count + CHG_W'(1);
        end
        res_status_next = STAT_OK;
        res_state_next  = s_new;
        res_supp_next   = fl_rdata[0];
        state_next      = S_FINISH;
      end

      S_SEARCH: begin
        if (id_rdata == {it_type, it_num}) begin
          case (it_cmd)
            CMD_SUPPRESS:   sup_new = 1'b1;
            CMD_UNSUPPRESS: sup_new = 1'b0;
            CMD_ACK: begin
              if (s_cur == ALM_ALARM) begin
                s_new = ALM_ACK;
              end else if (s_cur == ALM_RETURNED) begin
                s_new = ALM_NORMAL;
              end else begin
                st = STAT_REFUSED;
              end
            end
            default: st = STAT_BAD;
          endcase
          if (st == STAT_OK) begin
            fl_ctl.we         = 1'b1;
            fl_ctl.waddr      = idx;
            fl_wdata          = {s_new, sup_new};
            change_count_next = change_count + CHG_W'(1);
          end
          res_status_next = st;
          res_state_next  = s_new;
          res_supp_next   = sup_new;
          state_next      = S_FINISH;
        end else if ((CNT_W'(idx) + CNT_W'(1)) == count) begin
          res_status_next = STAT_NOMATCH;
          res_state_next  = ALM_NORMAL;
          res_supp_next   = 1'b0;
          state_next      = S_FINISH;
        end else begin
          // Advance to the next entry; both memories follow the same address.
          idx_next     = idx + ADDR_W'(1);
          id_ctl.re    = 1'b1;
          id_ctl.raddr = idx + ADDR_W'(1);
          fl_ctl.re    = 1'b1;
          fl_ctl.raddr = idx + ADDR_W'(1);
        end
      end

      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      round_fault   <= 1'b0;
      round_changed <= 1'b0;
      change_count  <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      round_fault   <= round_fault_next;
      round_changed <= round_changed_next;
      change_count  <= change_count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    it_last    <= it_last_next;
    it_fault   <= it_fault_next;
    it_cmd     <= it_cmd_next;
    it_type    <= it_type_next;
    it_num     <= it_num_next;
    res_status <= res_status_next;
    res_state  <= res_state_next;
    res_supp   <= res_supp_next;
    if (out_load) begin
      out_status <= res_status;
      out_state  <= res_state;
      suppressed <= res_supp;
      any_error  <= round_fault;
      new_error  <= round_changed;
      change_id  <= change_count;
    end
  end

  assign status      = out_status;
  assign alarm_state = out_state;

endmodule

// File: rtl/alat_checker.sv
// Port-level checks of the alarm annunciator table, bound to the top level.
module alat_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [1:0]  alarm_state,
  input logic        suppressed,
  input logic [15:0] change_id
);
  import alat_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(change_id))
    else $error("stalled result changed");

  // One request in flight: the port closes right after an acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while busy");

  // No affected channel reports a cleared channel.
  a_no_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_NOMATCH || status == STAT_FULL)
      |-> alarm_state == ALM_NORMAL && !suppressed)
    else $error("unaffected result carries channel state");

  // A refused acknowledge only happens on a normal or acknowledged channel.
  a_refused_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_REFUSED
      |-> alarm_state == ALM_NORMAL || alarm_state == ALM_ACK)
    else $error("acknowledge refused in an acknowledgeable state");

endmodule

bind alarm_annunciator_table_top alat_checker u_alat_checker (.*);
